### rtl/sme_pkg.sv
package sme_pkg;

	typedef enum logic [4:0] {
		OP_NOP   = 5'd0,
		OP_ADD   = 5'd1,
		OP_SUB   = 5'd2,
		OP_MUL   = 5'd3,
		OP_DIV   = 5'd4,
		OP_AND   = 5'd5,
		OP_OR    = 5'd6,
		OP_NOT   = 5'd7,
		OP_TSTEQ = 5'd8,
		OP_TSTNE = 5'd9,
		OP_TSTLT = 5'd10,
		OP_TSTLE = 5'd11,
		OP_TSTGT = 5'd12,
		OP_TSTGE = 5'd13,
		OP_PUSHL = 5'd14,
		OP_PUSHV = 5'd15,
		OP_POP   = 5'd16,
		OP_GET   = 5'd17,
		OP_PUT   = 5'd18,
		OP_J     = 5'd19,
		OP_JF    = 5'd20,
		OP_HALT  = 5'd21
	} op_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_DIV0  = 3'd1;
	localparam logic [2:0] ST_UNDER = 3'd2;
	localparam logic [2:0] ST_OVER  = 3'd3;
	localparam logic [2:0] ST_HALT  = 3'd4;

	// classified item handed from front to back
	typedef struct packed {
		logic [4:0]  opcode;
		logic [1:0]  pops;
		logic        pushes;
		logic [31:0] lit;
		logic [5:0]  vidx;
		logic [6:0]  tgt;
	} dec_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_POP1,
		EX_POP2,
		EX_CALC,
		EX_DIV,
		EX_OUT
	} ex_state_t;

endpackage

### rtl/sme_front.sv
module sme_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         req_type,
	input  logic signed [31:0] literal_value,
	input  logic [5:0]         var_index,
	input  logic [6:0]         jump_target,
	output logic               q_valid,
	input  logic               q_stall,
	output sme_pkg::dec_t      q_item
);

	// two-entry queue
	sme_pkg::dec_t fifo_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	sme_pkg::dec_t d;
	logic          push, pop;

	always_comb begin
		d = '0;
		d.opcode = req_type;
		d.lit    = literal_value;
		d.vidx   = var_index;
		d.tgt    = jump_target;
		case (req_type) inside
			[5'd1:5'd6]: begin
				d.pops = 2'd2;
				d.pushes = 1'b1;
			end
			[5'd7:5'd13]: begin
				d.pops = 2'd1;
				d.pushes = 1'b1;
			end
			5'd14, 5'd15: d.pushes = 1'b1;
			5'd16, 5'd20: d.pops = 2'd1;
			default: ;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && !q_stall;
	assign q_item   = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push)
		else $error("push into full queue");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop)
		else $error("pop from empty queue");

endmodule

### rtl/sme_div.sv
module sme_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] q_q, d_q, r_q;
	logic        neg_q, busy_q;
	logic [4:0]  n_q;
	logic [32:0] trial;

	assign trial = {r_q, q_q[31]} - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[31] ? 32'd0 - dividend : dividend;
			d_q   <= divisor[31] ? 32'd0 - divisor : divisor;
			r_q   <= '0;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) r_q <= trial[31:0];
			else r_q <= {r_q[30:0], q_q[31]};
			q_q <= {q_q[30:0], !trial[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end else if (busy_q) begin
				n_q <= n_q + 5'd1;
				if (n_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? 32'd0 - q_q : q_q;

endmodule

### rtl/sme_back.sv
module sme_back #(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT   = 64,
	parameter int PROG_SIZE   = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_stall,
	input  sme_pkg::dec_t      q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         next_pc,
	output logic               put_valid,
	output logic signed [31:0] put_value,
	output logic [2:0]         status
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int VAW = $clog2(VAR_COUNT);
	localparam int PCW = $clog2(PROG_SIZE);

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] vvalid_q;

	sme_pkg::ex_state_t state_q, state_d;
	sme_pkg::dec_t      it_q;
	logic [SPW-1:0]     sp_q;
	logic [PCW-1:0]     pc_q;
	logic               stopped_q;
	logic [31:0]        r_q, l_q, rd_stk, rd_var, res;
	logic [VAW-1:0]     vi;
	logic [PCW-1:0]     tgt, adv;
	logic [31:0]        mul_s1;
	logic               div_done;
	logic [31:0]        div_quo;
	logic               take, fin;
	logic [2:0]         st;

	// index and target folding as constant lookup tables
	logic [VAW-1:0] vi_tab [64];
	logic [PCW-1:0] tgt_tab [128];
	always_comb begin
		for (int k = 0; k < 64; k++) vi_tab[k] = VAW'(k % VAR_COUNT);
		for (int k = 0; k < 128; k++) tgt_tab[k] = PCW'(k % PROG_SIZE);
	end

	assign vi  = vi_tab[it_q.vidx];
	assign tgt = tgt_tab[it_q.tgt];
	assign adv = (32'(pc_q) + 32'd1 >= 32'(PROG_SIZE)) ? '0 : pc_q + PCW'(1);

	// a result waiting on out_stall keeps the next item out
	assign q_stall = (state_q != sme_pkg::EX_IDLE) || (out_valid && out_stall);
	assign take = (state_q == sme_pkg::EX_IDLE) && q_valid && !(out_valid && out_stall);

	// stack read port (registered data): top first, then the entry below it
	logic [SAW-1:0] rd_addr;
	always_comb begin
		if (state_q == sme_pkg::EX_POP1) rd_addr = SAW'(sp_q - SPW'(2));
		else rd_addr = SAW'(sp_q - SPW'(1));
	end
	always_ff @(posedge clk) rd_stk <= stk_mem[rd_addr];
	always_ff @(posedge clk) rd_var <= var_mem[vi];

	always_ff @(posedge clk) begin
		if (state_q == sme_pkg::EX_POP2) mul_s1 <= rd_stk * r_q;
	end

	sme_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == sme_pkg::EX_CALC && it_q.opcode == sme_pkg::OP_DIV
			&& r_q != '0),
		.dividend(l_q), .divisor(r_q), .done(div_done), .quotient(div_quo)
	);

	logic [31:0] var_val;
	assign var_val = vvalid_q[vi] ? rd_var : '0;

	always_comb begin
		case (it_q.opcode)
			sme_pkg::OP_ADD:   res = l_q + r_q;
			sme_pkg::OP_SUB:   res = l_q - r_q;
			sme_pkg::OP_MUL:   res = mul_s1;
			sme_pkg::OP_DIV:   res = div_quo;
			sme_pkg::OP_AND:   res = {31'd0, l_q != 0 && r_q != 0};
			sme_pkg::OP_OR:    res = {31'd0, l_q != 0 || r_q != 0};
			sme_pkg::OP_NOT,
			sme_pkg::OP_TSTEQ: res = {31'd0, r_q == 0};
			sme_pkg::OP_TSTNE: res = {31'd0, r_q != 0};
			sme_pkg::OP_TSTLT: res = {31'd0, r_q[31]};
			sme_pkg::OP_TSTLE: res = {31'd0, r_q[31] || r_q == 0};
			sme_pkg::OP_TSTGT: res = {31'd0, !r_q[31] && r_q != 0};
			sme_pkg::OP_TSTGE: res = {31'd0, !r_q[31]};
			sme_pkg::OP_PUSHL: res = it_q.lit;
			sme_pkg::OP_PUSHV: res = var_val;
			default:           res = '0;
		endcase
	end

	// error check at issue
	always_comb begin
		st = sme_pkg::ST_OK;
		if (sp_q < SPW'(it_q.pops)) st = sme_pkg::ST_UNDER;
		else if (it_q.pushes && it_q.pops == 2'd0 && sp_q >= SPW'(STACK_DEPTH))
			st = sme_pkg::ST_OVER;
	end

	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		case (state_q)
			sme_pkg::EX_IDLE: if (take) state_d = sme_pkg::EX_POP1;
			sme_pkg::EX_POP1: begin
				if (stopped_q || st != sme_pkg::ST_OK) state_d = sme_pkg::EX_OUT;
				else if (it_q.pops != 2'd0) state_d = sme_pkg::EX_POP2;
				else state_d = sme_pkg::EX_CALC;
			end
			sme_pkg::EX_POP2: state_d = sme_pkg::EX_CALC;
			sme_pkg::EX_CALC: begin
				if (it_q.opcode == sme_pkg::OP_DIV && r_q != '0)
					state_d = sme_pkg::EX_DIV;
				else begin
					state_d = sme_pkg::EX_OUT;
					fin = !(it_q.opcode == sme_pkg::OP_DIV);
				end
			end
			sme_pkg::EX_DIV: if (div_done) begin
				state_d = sme_pkg::EX_OUT;
				fin = 1'b1;
			end
			sme_pkg::EX_OUT: if (!out_valid || !out_stall) state_d = sme_pkg::EX_IDLE;
			default: state_d = sme_pkg::EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sme_pkg::EX_IDLE;
		else state_q <= state_d;
	end

	// POP1 loads the top, POP2 the entry below; the product is registered in POP2
	always_ff @(posedge clk) begin
		if (take) it_q <= q_item;
		if (state_q == sme_pkg::EX_POP1) r_q <= rd_stk;
		if (state_q == sme_pkg::EX_POP2) l_q <= rd_stk;
	end

	// pending output register
	logic [PCW-1:0]   opc_q;
	logic             opv_q;
	logic [31:0]      oval_q;
	logic [2:0]       ost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
			vvalid_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == sme_pkg::EX_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == sme_pkg::EX_POP1) begin
				if (stopped_q) begin
					opc_q <= pc_q; opv_q <= 1'b0; oval_q <= '0; ost_q <= sme_pkg::ST_HALT;
				end else if (st != sme_pkg::ST_OK) begin
					stopped_q <= 1'b1;
					opc_q <= pc_q; opv_q <= 1'b0; oval_q <= '0; ost_q <= st;
				end else if (it_q.pops != 2'd0) sp_q <= sp_q - SPW'(1);
			end
			if (state_q == sme_pkg::EX_POP2 && it_q.pops == 2'd2) sp_q <= sp_q - SPW'(1);
			if (state_q == sme_pkg::EX_CALC && it_q.opcode == sme_pkg::OP_DIV
				&& r_q == '0) begin
				stopped_q <= 1'b1;
				sp_q <= sp_q + SPW'(2);
				opc_q <= pc_q; opv_q <= 1'b0; oval_q <= '0; ost_q <= sme_pkg::ST_DIV0;
			end
			if (fin) begin
				opv_q  <= it_q.opcode == sme_pkg::OP_PUT;
				oval_q <= (it_q.opcode == sme_pkg::OP_PUT) ? var_val : '0;
				ost_q  <= (it_q.opcode == sme_pkg::OP_HALT) ? sme_pkg::ST_HALT
					: sme_pkg::ST_OK;
				case (it_q.opcode)
					sme_pkg::OP_J: begin pc_q <= tgt; opc_q <= tgt; end
					sme_pkg::OP_JF: begin
						pc_q  <= (r_q != 32'd1) ? tgt : adv;
						opc_q <= (r_q != 32'd1) ? tgt : adv;
					end
					default: begin pc_q <= adv; opc_q <= adv; end
				endcase
				if (it_q.opcode == sme_pkg::OP_HALT) stopped_q <= 1'b1;
				if (it_q.pushes) sp_q <= sp_q + SPW'(1);
				if (it_q.opcode == sme_pkg::OP_POP || it_q.opcode == sme_pkg::OP_GET)
					vvalid_q[vi] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && it_q.pushes) stk_mem[SAW'(sp_q)] <= res;
		if (fin && it_q.opcode == sme_pkg::OP_POP) var_mem[vi] <= r_q;
		if (fin && it_q.opcode == sme_pkg::OP_GET) var_mem[vi] <= it_q.lit;
	end

	assign next_pc   = 7'(opc_q);
	assign put_valid = opv_q;
	assign put_value = oval_q;
	assign status    = ost_q;

	a_sp: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stopped_q) |-> stopped_q)
		else $error("stopped flag cleared");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sme_pkg::EX_IDLE |-> q_stall)
		else $error("took item while busy");

endmodule

### rtl/stack_machine_execute.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | req_type literal_value var_index jump_target
// out     | out_valid | out_stall | next_pc put_valid put_value status
//
// an item passes POP1, CALC and OUT, with POP2 before CALC when it pops operands
// a stopped block, an underflow or an overflow goes from POP1 straight to OUT
// div adds DIV for the radix-2 divider; stack and variable reads are registered
// a result held by out_stall keeps the back from taking the next item
// the front queue holds two items so input keeps flowing while back is busy
// arst_n clears pc, stack pointer, stopped flag and variable valid bits
module stack_machine_execute #(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT   = 64,
	parameter int PROG_SIZE   = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         req_type,
	input  logic signed [31:0] literal_value,
	input  logic [5:0]         var_index,
	input  logic [6:0]         jump_target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         next_pc,
	output logic               put_valid,
	output logic signed [31:0] put_value,
	output logic [2:0]         status
);

	// classified item between front and back
	logic          q_valid, q_stall;
	sme_pkg::dec_t q_item;

	sme_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .literal_value(literal_value),
		.var_index(var_index), .jump_target(jump_target),
		.q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
	);

	sme_back #(
		.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT), .PROG_SIZE(PROG_SIZE)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_stall(q_stall), .q_item(q_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .put_valid(put_valid),
		.put_value(put_value), .status(status)
	);

endmodule

### test/sme_checker.sv
module sme_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [4:0]         req_type,
	input  logic signed [31:0] literal_value,
	input  logic [5:0]         var_index,
	input  logic [6:0]         jump_target,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [6:0]         next_pc,
	input  logic               put_valid,
	input  logic signed [31:0] put_value,
	input  logic [2:0]         status,
	output int                 mismatch_count,
	output int                 pending
);

	typedef struct {
		logic [6:0]  npc;
		logic        pv;
		logic [31:0] pval;
		logic [2:0]  st;
	} step_result_t;

	step_result_t expected_steps[$];
	logic [31:0]  shadow_stack [64];
	logic [31:0]  shadow_vars [64];
	logic [6:0]   shadow_sp;
	logic [6:0]   shadow_pc;
	logic         shadow_stopped;

	assign pending = expected_steps.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	task automatic execute_step(input logic [4:0] op, input logic [31:0] lit,
			input logic [5:0] vi, input logic [6:0] tgt);
		step_result_t res;
		logic [31:0] l, r, v;
		int pops;
		bit pushes;
		res.npc = shadow_pc + 7'd1;
		res.pv = 1'b0;
		res.pval = '0;
		res.st = sme_pkg::ST_OK;
		l = '0;
		r = '0;
		v = '0;
		pops = 0;
		pushes = 0;
		if (shadow_stopped) begin
			res.npc = shadow_pc;
			res.st = sme_pkg::ST_HALT;
			expected_steps.push_back(res);
			return;
		end
		if (op >= sme_pkg::OP_ADD && op <= sme_pkg::OP_OR) begin
			pops = 2;
			pushes = 1;
		end else if (op >= sme_pkg::OP_NOT && op <= sme_pkg::OP_TSTGE) begin
			pops = 1;
			pushes = 1;
		end else if (op == sme_pkg::OP_PUSHL || op == sme_pkg::OP_PUSHV) begin
			pushes = 1;
		end else if (op == sme_pkg::OP_POP || op == sme_pkg::OP_JF) begin
			pops = 1;
		end
		if (shadow_sp < pops) res.st = sme_pkg::ST_UNDER;
		else if (pushes && pops == 0 && shadow_sp >= 64) res.st = sme_pkg::ST_OVER;
		else if (op == sme_pkg::OP_DIV && shadow_stack[shadow_sp - 1] == 0)
			res.st = sme_pkg::ST_DIV0;
		if (res.st != sme_pkg::ST_OK) begin
			shadow_stopped = 1'b1;
			res.npc = shadow_pc;
		end else begin
			if (pops >= 1) begin
				shadow_sp--;
				r = shadow_stack[shadow_sp];
			end
			if (pops >= 2) begin
				shadow_sp--;
				l = shadow_stack[shadow_sp];
			end
			case (op)
				sme_pkg::OP_ADD:   v = l + r;
				sme_pkg::OP_SUB:   v = l - r;
				sme_pkg::OP_MUL:   v = l * r;
				sme_pkg::OP_DIV:   v = div_trunc(l, r);
				sme_pkg::OP_AND:   v = 32'(l != 0 && r != 0);
				sme_pkg::OP_OR:    v = 32'(l != 0 || r != 0);
				sme_pkg::OP_NOT:   v = 32'(r == 0);
				sme_pkg::OP_TSTEQ: v = 32'(r == 0);
				sme_pkg::OP_TSTNE: v = 32'(r != 0);
				sme_pkg::OP_TSTLT: v = 32'(r[31]);
				sme_pkg::OP_TSTLE: v = 32'(r[31] || r == 0);
				sme_pkg::OP_TSTGT: v = 32'(!r[31] && r != 0);
				sme_pkg::OP_TSTGE: v = 32'(!r[31]);
				sme_pkg::OP_PUSHL: v = lit;
				sme_pkg::OP_PUSHV: v = shadow_vars[vi];
				sme_pkg::OP_POP:   shadow_vars[vi] = r;
				sme_pkg::OP_GET:   shadow_vars[vi] = lit;
				sme_pkg::OP_PUT: begin
					res.pv = 1'b1;
					res.pval = shadow_vars[vi];
				end
				sme_pkg::OP_J:     res.npc = tgt;
				sme_pkg::OP_JF:    if (r != 1) res.npc = tgt;
				sme_pkg::OP_HALT: begin
					res.st = sme_pkg::ST_HALT;
					shadow_stopped = 1'b1;
				end
				default: ;
			endcase
			if (pushes) begin
				shadow_stack[shadow_sp] = v;
				shadow_sp++;
			end
		end
		shadow_pc = res.npc;
		expected_steps.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			shadow_sp = '0;
			shadow_pc = '0;
			shadow_stopped = 1'b0;
			foreach (shadow_vars[i]) shadow_vars[i] = '0;
		end else begin
			if (in_valid && !in_stall)
				execute_step(req_type, literal_value, var_index, jump_target);
			if (out_valid && !out_stall) begin
				if (expected_steps.size() == 0) begin
					report("unexpected item", {25'd0, next_pc}, '0);
				end else begin
					want = expected_steps.pop_front();
					if (next_pc !== want.npc)
						report("next_pc", 32'(next_pc), 32'(want.npc));
					if (put_valid !== want.pv)
						report("put_valid", 32'(put_valid), 32'(want.pv));
					if (put_value !== want.pval) report("put_value", put_value, want.pval);
					if (status !== want.st)
						report("status", 32'(status), 32'(want.st));
				end
			end
		end
	end
endmodule

### test/testbench.sv
module testbench;
	import sme_pkg::*;

	// opcodes past halt decode as nop
	localparam logic [4:0] OP_SPARE_LO = 5'd22;
	localparam logic [4:0] OP_SPARE_HI = 5'd31;
	localparam int RANDOM_ITEMS = 600;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [4:0]         req_type = '0;
	logic signed [31:0] literal_value = '0;
	logic [5:0]         var_index = '0;
	logic [6:0]         jump_target = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [6:0]         next_pc;
	logic               put_valid;
	logic signed [31:0] put_value;
	logic [2:0]         status;
	int                 mismatch_count;
	int                 pending;

	// idle percentages, changed per phase
	int  send_idle_pct = 10;
	int  recv_stall_pct = 45;
	// operand depth as the program sees it, to keep sequences well formed
	int  depth = 0;

	always #6 clk = ~clk;

	stack_machine_execute DUT (.*);

	sme_checker u_checker (.*);

	// receiver stalls at random
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// present one item and hold it until the block takes it
	task automatic issue(input logic [4:0] op, input logic [31:0] lit,
			input logic [5:0] vi, input logic [6:0] tgt);
		logic stalled;
		// random gap before the item
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		literal_value <= lit;
		var_index <= vi;
		jump_target <= tgt;
		// stall is settled by the falling edge, so sample it there
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		// track depth for the error-free cases only
		if (op >= OP_ADD && op <= OP_OR) depth -= 1;
		else if (op == OP_POP || op == OP_JF) depth -= 1;
		else if (op == OP_PUSHL || op == OP_PUSHV) depth += 1;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return 32'd1;
			5: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	// one random instruction that stays clear of every stopping case
	task automatic random_instruction();
		logic [4:0]  op;
		logic [31:0] lit;
		int          pick;
		lit = pick_value();
		pick = $urandom_range(99);
		if (depth < 2 && pick < 50) pick = 60;
		if (depth < 1 && pick < 70) pick = 75;
		if (depth >= 60 && pick >= 70 && pick < 85) pick = 40;
		if (pick < 8) begin
			// divide by a known nonzero top
			if (depth >= 63) issue(OP_POP, '0, $urandom, '0);
			lit = $urandom;
			if (lit == 0) lit = 32'hffff_ffff;
			issue(OP_PUSHL, lit, '0, '0);
			issue(OP_DIV, $urandom, $urandom, $urandom);
		end else if (pick < 50) begin
			op = op_t'($urandom_range(OP_ADD, OP_OR));
			if (op == OP_DIV) op = OP_MUL;
			issue(op, $urandom, $urandom, $urandom);
		end else if (pick < 60) begin
			issue(5'($urandom_range(OP_NOT, OP_TSTGE)), $urandom, $urandom, $urandom);
		end else if (pick < 70) begin
			issue($urandom_range(1) ? OP_POP : OP_JF, $urandom, $urandom, $urandom);
		end else if (pick < 85) begin
			issue($urandom_range(2) ? OP_PUSHL : OP_PUSHV, lit, $urandom, $urandom);
		end else if (pick < 93) begin
			issue($urandom_range(1) ? OP_GET : OP_PUT, lit, $urandom, $urandom);
		end else if (pick < 96) begin
			issue(OP_J, $urandom, $urandom, $urandom);
		end else begin
			op = $urandom_range(1) ? OP_NOP : 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			issue(op, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		#(12 * 400000);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and every operation but tstne, tstle, tstgt and halt
		issue(OP_GET, 32'h8000_0000, 6'd63, '0);
		issue(OP_PUT, '0, 6'd63, '0);
		issue(OP_PUSHV, '0, 6'd63, '0);
		issue(OP_PUSHL, 32'hffff_ffff, '0, '0);
		// most negative over minus one wraps
		issue(OP_DIV, '0, '0, '0);
		issue(OP_TSTLT, '0, '0, '0);
		issue(OP_PUSHL, 32'h7fff_ffff, '0, '0);
		issue(OP_PUSHL, 32'h7fff_ffff, '0, '0);
		issue(OP_ADD, '0, '0, '0);
		issue(OP_PUSHL, 32'd3, '0, '0);
		issue(OP_MUL, '0, '0, '0);
		issue(OP_PUSHL, -32'd7, '0, '0);
		issue(OP_DIV, '0, '0, '0);
		issue(OP_PUSHL, 32'h8000_0000, '0, '0);
		issue(OP_SUB, '0, '0, '0);
		issue(OP_TSTGE, '0, '0, '0);
		issue(OP_AND, '0, '0, '0);
		issue(OP_PUSHL, '0, '0, '0);
		issue(OP_OR, '0, '0, '0);
		issue(OP_NOT, '0, '0, '0);
		// jf not taken on exactly one, then jump to the top address
		issue(OP_JF, '0, '0, 7'd127);
		issue(OP_J, '0, '0, 7'd127);
		issue(OP_NOP, '0, '0, '0);
		issue(OP_SPARE_HI, 32'hffff_ffff, 6'd63, 7'd127);
		issue(OP_PUSHL, '0, '0, '0);
		issue(OP_TSTEQ, '0, '0, '0);
		issue(OP_JF, '0, '0, 7'd5);
		issue(OP_PUSHL, 32'd5, '0, '0);
		issue(OP_POP, '0, '0, '0);

		// random, three idle phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 45;
				recv_stall_pct = 10;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			random_instruction();
		end

		// finish with one stopping case, then items on the stopped block
		case ($urandom_range(3))
			0: issue(OP_HALT, '0, '0, '0);
			1: begin
				while (depth > 0) issue(OP_POP, '0, $urandom, '0);
				issue(OP_ADD, '0, '0, '0);
			end
			2: begin
				while (depth < 64) issue(OP_PUSHL, $urandom, '0, '0);
				issue(OP_PUSHV, '0, '0, '0);
			end
			default: begin
				issue(OP_PUSHL, 32'd9, '0, '0);
				issue(OP_PUSHL, '0, '0, '0);
				issue(OP_DIV, '0, '0, '0);
			end
		endcase
		issue(OP_PUSHL, 32'd1, '0, '0);
		issue(OP_PUT, '0, 6'd1, '0);
		issue(OP_J, '0, '0, 7'd9);
		in_valid <= 1'b0;

		// drain until nothing is pending, then idle on before the verdict
		waited = 0;
		while (pending != 0) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
